/* src/atlb_pkg.sv */
// Shared constants and types for the fully associative translation buffer.
package atlb_pkg;

    localparam int ENTRIES = 16;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed {
        logic take_in;   // latch the incoming beat
        logic compare;   // tag compare across all entries
        logic move;      // recency reorder and load the result register
    } atlb_cmd_t;

endpackage

/* src/atlb_ctrl.sv */
// Sequencer for the translation buffer: handshakes and compare/reorder steps.
module atlb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output atlb_pkg::atlb_cmd_t cmd
);
    import atlb_pkg::*;

    localparam logic [1:0] IDLE = 2'd0;
    localparam logic [1:0] LOOK = 2'd1;
    localparam logic [1:0] MOVE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg == LOOK) || (state_reg == MOVE && !out_free);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take_in = in_valid && !in_stall;
        cmd.compare = (state_reg == LOOK);
        cmd.move    = (state_reg == MOVE) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (cmd.take_in)
                    state_next = LOOK;
            end
            LOOK:
            begin
                state_next = MOVE;
            end
            MOVE:
            begin
                if (out_free)
                    state_next = cmd.take_in ? LOOK : IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.move ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_look_then_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LOOK) |=> (state_reg == MOVE))
        else $error("compare step not followed by reorder");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_in |=> (state_reg == LOOK))
        else $error("accepted beat not compared");

    a_result_from_move: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == MOVE))
        else $error("result raised outside reorder step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.move)
        else $error("pending result overwritten");

endmodule

/* src/atlb_dp.sv */
// Datapath: entry store in recency order, parallel tag compare, result register.
module atlb_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  atlb_pkg::atlb_cmd_t cmd,
    input  logic                kind,
    input  atlb_pkg::page_t     page,
    input  atlb_pkg::frame_t    frame_in,
    output logic                hit,
    output atlb_pkg::frame_t    frame_out
);
    import atlb_pkg::*;

    logic [ENTRIES-1:0] slot_valid_reg;
    page_t              slot_page_reg  [ENTRIES];
    frame_t             slot_frame_reg [ENTRIES];

    logic   req_kind_reg;
    page_t  req_page_reg;
    frame_t req_frame_reg;

    logic [ENTRIES-1:0] match_next;
    logic [ENTRIES-1:0] match_reg;
    logic               hit_reg;
    frame_t             hit_frame_next;
    frame_t             hit_frame_reg;

    logic [ENTRIES-1:0] at_or_after;
    logic [ENTRIES-1:0] shift_en;
    logic               write_front;
    frame_t             front_frame;

    logic   hit_out_reg;
    frame_t frame_out_reg;

    always_comb
    begin
        hit_frame_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_next[i] = slot_valid_reg[i] && (slot_page_reg[i] == req_page_reg);
            hit_frame_next = hit_frame_next | (slot_frame_reg[i] & {FRAME_W{match_next[i]}});
        end
    end

    // An entry shifts back when the hit lies at or behind it, or on a new insert.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_mask
        assign at_or_after[g] = |match_reg[ENTRIES-1:g];
        assign shift_en[g]    = hit_reg ? at_or_after[g] : req_kind_reg;
    end

    assign write_front = hit_reg || req_kind_reg;
    assign front_frame = hit_reg ? hit_frame_reg : req_frame_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            req_kind_reg  <= kind;
            req_page_reg  <= page;
            req_frame_reg <= frame_in;
        end
        if (cmd.compare)
        begin
            match_reg     <= match_next;
            hit_reg       <= |match_next;
            hit_frame_reg <= hit_frame_next;
        end
        if (cmd.move)
        begin
            hit_out_reg   <= hit_reg;
            frame_out_reg <= hit_frame_reg;
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (shift_en[i])
                begin
                    slot_page_reg[i]  <= slot_page_reg[i-1];
                    slot_frame_reg[i] <= slot_frame_reg[i-1];
                end
            end
            if (write_front)
            begin
                slot_page_reg[0]  <= req_page_reg;
                slot_frame_reg[0] <= front_frame;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (cmd.move)
        begin
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (shift_en[i])
                    slot_valid_reg[i] <= slot_valid_reg[i-1];
            end
            if (write_front)
                slot_valid_reg[0] <= 1'b1;
        end
    end

    assign hit       = hit_out_reg;
    assign frame_out = frame_out_reg;

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((slot_valid_reg + 1'b1) & slot_valid_reg) == '0)
        else $error("valid entries do not form a prefix");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |-> $onehot0(match_next))
        else $error("page held in more than one entry");

    a_hit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |=> (hit_reg == (match_reg != '0)))
        else $error("hit flag disagrees with match vector");

endmodule

/* src/assoc_tlb_lru.sv */
// Top level of the fully associative translation buffer with LRU replacement.
// Each input beat is a lookup (kind 0) or an insert (kind 1) and yields exactly one
// result beat: hit, and the stored frame on a hit or 0 otherwise. An item passes a
// compare step, which matches the page against every entry at once, then a reorder
// step, which moves the entry to the front of the recency order (or shifts in a new
// one, dropping the least recent) and loads the result register. A new beat can be
// taken in the reorder step while the result side keeps up; a stalled result holds
// the block in the reorder step. Valid marks clear on reset; no clearing pass.
module assoc_tlb_lru (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             kind,
    input  atlb_pkg::page_t  page,
    input  atlb_pkg::frame_t frame_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             hit,
    output atlb_pkg::frame_t frame_out
);
    import atlb_pkg::*;

    atlb_cmd_t cmd;

    atlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    atlb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (kind),
        .page      (page),
        .frame_in  (frame_in),
        .hit       (hit),
        .frame_out (frame_out)
    );

endmodule

/* dv/tb.sv */
// Testbench for assoc_tlb_lru: queued stimulus, clocked driver and monitor, LRU predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atlb_pkg::*;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;
    localparam int   RAND_ITEMS  = 750;
    localparam int   MAX_SHOWN   = 10;
    localparam int   WDOG_LIMIT  = 2000;
    localparam int   TAIL_CYCLES = 20;

    typedef struct {
        logic   kind;
        page_t  page;
        frame_t frame;
        bit     drain;
    } xlate_req_t;

    typedef struct packed {
        logic   hit;
        frame_t frame;
    } xlate_rsp_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_stall;
    logic   kind      = KIND_LOOKUP;
    page_t  page      = '0;
    frame_t frame_in  = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   hit;
    frame_t frame_out;

    xlate_req_t pending [$];
    xlate_rsp_t translations [$];
    int         n_items;
    int         n_sent;
    int         fails;
    int         quiet_cycles;
    bit         in_taken;

    logic   lru_valid [ENTRIES];
    page_t  lru_page  [ENTRIES];
    frame_t lru_frame [ENTRIES];

    assoc_tlb_lru uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .page      (page),
        .frame_in  (frame_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .frame_out (frame_out)
    );

    always #5 clk = ~clk;

    // Slot 0 is most recent; a hit or a new insert shifts the slots ahead of it back by one.
    function automatic xlate_rsp_t translate(logic is_ins, page_t pg, frame_t fr);
        xlate_rsp_t rsp;
        int         idx;
        int         last;
        rsp = '0;
        idx = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (idx < 0 && lru_valid[i] && lru_page[i] == pg)
            begin
                idx = i;
            end
        end
        if (idx >= 0 || is_ins == KIND_INSERT)
        begin
            if (idx >= 0)
            begin
                rsp.hit   = 1'b1;
                rsp.frame = lru_frame[idx];
                last      = idx;
            end
            else
            begin
                last = ENTRIES - 1;
            end
            for (int i = last; i > 0; i--)
            begin
                lru_valid[i] = lru_valid[i-1];
                lru_page[i]  = lru_page[i-1];
                lru_frame[i] = lru_frame[i-1];
            end
            lru_valid[0] = 1'b1;
            lru_page[0]  = pg;
            lru_frame[0] = (idx >= 0) ? rsp.frame : fr;
        end
        return rsp;
    endfunction

    function automatic void add_item(logic k, page_t pg, frame_t fr, bit drain = 1'b0);
        xlate_req_t req;
        req.kind  = k;
        req.page  = pg;
        req.frame = fr;
        req.drain = drain;
        pending.push_back(req);
    endfunction

    always @(posedge clk)
    begin : monitor
        xlate_rsp_t want;
        bit         moved;
        in_taken = 1'b0;
        moved    = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (translations.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_SHOWN)
                    begin
                        $display("unexpected result beat: hit %0b frame %02h", hit, frame_out);
                    end
                end
                else
                begin
                    want = translations.pop_front();
                    if (hit !== want.hit || frame_out !== want.frame)
                    begin
                        fails++;
                        if (fails <= MAX_SHOWN)
                        begin
                            $display("mismatch: expected hit %0b frame %02h, got hit %0b frame %02h",
                                     want.hit, want.frame, hit, frame_out);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                moved    = 1'b1;
                in_taken = 1'b1;
                n_sent++;
                translations.push_back(translate(kind, page, frame_in));
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin : driver
        int in_idle;
        int out_idle;
        if (n_sent < n_items / 3)
        begin
            in_idle  = 14;
            out_idle = 88;
        end
        else if (n_sent < 2 * n_items / 3)
        begin
            in_idle  = 88;
            out_idle = 14;
        end
        else
        begin
            in_idle  = 0;
            out_idle = 0;
        end
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                // a drain beat is held back until every translation has returned
                if (pending.size() != 0 && !(pending[0].drain && translations.size() != 0)
                    && $urandom_range(99) >= in_idle)
                begin
                    kind     <= pending[0].kind;
                    page     <= pending[0].page;
                    frame_in <= pending[0].frame;
                    in_valid <= 1'b1;
                    pending.delete(0);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < out_idle);
        end
    end

    initial
    begin : stimulus
        page_t pool [$];
        int    pool_len;
        page_t pg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            lru_valid[i] = 1'b0;
        end

        add_item(KIND_LOOKUP, 8'h00, 8'hFF);            // miss on empty buffer
        add_item(KIND_INSERT, 8'h00, 8'hFF);
        add_item(KIND_LOOKUP, 8'h00, 8'h00);
        add_item(KIND_INSERT, 8'h00, 8'h12);            // already present, frame kept
        add_item(KIND_INSERT, 8'hFF, 8'h00);
        add_item(KIND_LOOKUP, 8'hFF, 8'hAA);
        for (int i = 1; i <= 14; i++)
        begin
            add_item(KIND_INSERT, page_t'(i), frame_t'(i * 17));
        end
        add_item(KIND_INSERT, 8'h80, 8'h5A);            // full, evicts page 0
        add_item(KIND_LOOKUP, 8'h00, 8'h00);
        add_item(KIND_LOOKUP, 8'hFF, 8'h00, 1'b1);      // hit on least recent entry

        // working sets of varying size: some fit, some thrash
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 96 == 0)
            begin
                pool_len = $urandom_range(40, 6);
                pool.delete();
                repeat (pool_len)
                begin
                    pool.push_back(page_t'($urandom_range(255)));
                end
            end
            if ($urandom_range(99) < 85)
            begin
                pg = pool[$urandom_range(pool_len - 1)];
            end
            else
            begin
                pg = page_t'($urandom_range(255));
            end
            add_item(($urandom_range(99) < 45) ? KIND_LOOKUP : KIND_INSERT, pg,
                     frame_t'($urandom_range(255)),
                     n == RAND_ITEMS / 3 || n == RAND_ITEMS / 2 || $urandom_range(99) == 0);
        end
        n_items = pending.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || translations.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fails == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
